// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants for the LRU cache simulator
// Command and outcome codes, register map and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacl_pkg;

  // Fixed field widths
  localparam int CMD_W        = 2;
  localparam int OUTCOME_W    = 2;
  localparam int CNT_W        = 32;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } reg_idx_e;

  // Access kind carried on the input tuser; unknown codes act as a load
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  // Outcome of the first access
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

endpackage

// ===== rtl/set_assoc_cache_lru_sim_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_core: set-associative cache outcome simulator
// Tracks valid bits, tags and LRU ages per set and reports hit, fill or
// eviction for each access together with running totals.
// ----------------------------------------------------------------------------
// Each access is taken one at a time. From the accepting edge to a result in
// the output register it passes through a split step that splits the address
// and reads the set, a scan step in which a single tag/age comparator walks
// the E ways of the set, where E is the number of ways in use, an update step
// in which the same age logic rebuilds all MAX_WAYS ways of the row way by
// way, and a write-back step. Ready comes back in the cycle after the
// write-back, so a new access is accepted only after the last one has been
// written back. The result register lets the next access start while a result
// still waits; that access then holds in the write-back step until the waiting
// result has been taken. After reset the valid/age memory is swept clear, one
// set per cycle; no access is taken during the sweep, but register writes are.
// Tags are only written on misses and are never cleared.
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_core #(
  parameter int MAX_SETS      = 64,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64,
  localparam int ADDR_BYTES_W = ((ADDRESS_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Access stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ADDR_BYTES_W-1:0]           s_axis_tdata,  // address
  input  logic [sacl_pkg::CMD_W-1:0]        s_axis_tuser,  // command

  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [3*sacl_pkg::CNT_W-1:0]      m_axis_tdata,  // total_hits, total_misses,
                                                           // total_evictions
  output logic [sacl_pkg::OUTCOME_W:0]      m_axis_tuser,  // outcome, second_hit

  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]      paddr,
  input  logic [sacl_pkg::PDATA_W-1:0]      pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  import sacl_pkg::*;

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;   // floor(log2(MAX_SETS))
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int AGE_W   = WAY_W;
  localparam int TAG_W   = ADDRESS_WIDTH;
  localparam int ST_W    = AGE_W + 1;                  // age, valid on top
  localparam int SHIFT_W = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_SCAN,
    ST_UPDATE,
    ST_WRITE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]       ways_q;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= WAYS_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SET_BITS:   set_bits_q   <= pwdata[SET_BITS_W-1:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[BLOCK_BITS_W-1:0];
        REG_WAYS:       ways_q       <= pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SET_BITS:   prdata = PDATA_W'(set_bits_q);
      REG_BLOCK_BITS: prdata = PDATA_W'(block_bits_q);
      REG_WAYS:       prdata = PDATA_W'(ways_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective geometry
  // --------------------------------------------------------------------------
  logic [SET_BITS_W-1:0] s_eff;
  logic [WCNT_W-1:0]     ways_eff;
  logic [AGE_W-1:0]      top_age;
  logic [SET_W-1:0]      set_mask;

  assign s_eff = (int'(set_bits_q) > SET_LOG) ? SET_BITS_W'(SET_LOG) : set_bits_q;

  always_comb begin
    if (ways_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_q);
    end
  end

  assign top_age = AGE_W'(ways_eff - WCNT_W'(1));

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(s_eff));
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_e             state_q;
  logic [SET_W-1:0]   clr_q;
  cmd_e               cmd_q;
  logic [TAG_W-1:0]   addr_q;
  logic [SET_W-1:0]   set_q;
  logic [TAG_W-1:0]   tag_q;
  logic [WAY_W-1:0]   way_q;
  logic               hit_q;
  logic [WAY_W-1:0]   hit_way_q;
  logic [AGE_W-1:0]   hit_age_q;
  logic               inv_q;
  logic [WAY_W-1:0]   inv_way_q;
  logic [AGE_W-1:0]   max_age_q;
  logic [WAY_W-1:0]   max_way_q;
  logic               upd_valid_q [MAX_WAYS];
  logic [AGE_W-1:0]   upd_age_q   [MAX_WAYS];
  logic [CNT_W-1:0]   hits_q;
  logic [CNT_W-1:0]   misses_q;
  logic [CNT_W-1:0]   evicts_q;
  logic               out_valid_q;
  outcome_e           out_outcome_q;
  logic               out_second_q;

  // --------------------------------------------------------------------------
  // Address split
  // --------------------------------------------------------------------------
  logic [SHIFT_W-1:0] tag_shift;
  logic [TAG_W-1:0]   block_addr;
  logic [SET_W-1:0]   set_d;
  logic [TAG_W-1:0]   tag_d;

  assign tag_shift  = SHIFT_W'(block_bits_q) + SHIFT_W'(s_eff);
  assign block_addr = addr_q >> block_bits_q;
  assign set_d      = block_addr[SET_W-1:0] & set_mask;
  assign tag_d      = addr_q >> tag_shift;

  // --------------------------------------------------------------------------
  // Set memories: valid/age rows (swept after reset) and tag rows
  // --------------------------------------------------------------------------
  logic                      st_we;
  logic [SET_W-1:0]          st_waddr;
  logic [MAX_WAYS*ST_W-1:0]  st_wdata;
  logic [MAX_WAYS*ST_W-1:0]  st_rdata;
  logic                      tag_we;
  logic [MAX_WAYS*TAG_W-1:0] tag_wdata;
  logic [MAX_WAYS*TAG_W-1:0] tag_rdata;
  logic                      rd_en;
  logic                      write_fire;

  assign rd_en      = (state_q == ST_SPLIT);
  assign write_fire = (state_q == ST_WRITE) && (!out_valid_q || m_axis_tready);
  assign st_we      = (state_q == ST_CLEAR) || write_fire;
  assign st_waddr   = (state_q == ST_CLEAR) ? clr_q : set_q;
  assign tag_we     = write_fire && !hit_q;

  sacl_ram #(
    .WIDTH (MAX_WAYS * ST_W),
    .DEPTH (MAX_SETS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (set_d),
    .rdata_o (st_rdata)
  );

  sacl_ram #(
    .WIDTH (MAX_WAYS * TAG_W),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q),
    .wdata_i (tag_wdata),
    .re_i    (rd_en),
    .raddr_i (set_d),
    .rdata_o (tag_rdata)
  );

  // Per-way views of the row read
  logic             rd_valid [MAX_WAYS];
  logic [AGE_W-1:0] rd_age   [MAX_WAYS];
  logic [TAG_W-1:0] rd_tag   [MAX_WAYS];
  logic [WAY_W-1:0] victim;

  assign victim = inv_q ? inv_way_q : max_way_q;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      rd_age[i]   = st_rdata[i*ST_W +: AGE_W];
      rd_valid[i] = st_rdata[i*ST_W + AGE_W];
      rd_tag[i]   = tag_rdata[i*TAG_W +: TAG_W];
      // write-back rows: cleared during the sweep
      if (state_q == ST_CLEAR) begin
        st_wdata[i*ST_W +: ST_W] = '0;
      end else begin
        st_wdata[i*ST_W +: ST_W] = {upd_valid_q[i], upd_age_q[i]};
      end
      tag_wdata[i*TAG_W +: TAG_W] = (WAY_W'(i) == victim) ? tag_q : rd_tag[i];
    end
  end

  // --------------------------------------------------------------------------
  // Shared way unit: one way per cycle, used for scan and for the age update
  // --------------------------------------------------------------------------
  logic             cur_valid;
  logic [AGE_W-1:0] cur_age;
  logic             cur_match;
  logic             cur_in_use;
  logic             scan_last;
  logic             upd_last;
  logic             nxt_valid;
  logic [AGE_W-1:0] nxt_age;

  assign cur_valid  = rd_valid[way_q];
  assign cur_age    = rd_age[way_q];
  assign cur_match  = cur_valid && (rd_tag[way_q] == tag_q);
  assign cur_in_use = (WCNT_W'(way_q) < ways_eff);
  assign scan_last  = (WCNT_W'(way_q) == ways_eff - WCNT_W'(1));
  assign upd_last   = (way_q == WAY_W'(MAX_WAYS - 1));

  always_comb begin
    nxt_valid = cur_valid;
    nxt_age   = cur_age;
    if (cur_in_use) begin
      if (hit_q) begin
        if (way_q == hit_way_q) begin
          nxt_age = '0;
        end else if (cur_age < hit_age_q) begin
          nxt_age = cur_age + AGE_W'(1);
        end
      end else if (way_q == victim) begin
        nxt_valid = 1'b1;
        nxt_age   = '0;
      end else begin
        nxt_age = (cur_age < top_age) ? cur_age + AGE_W'(1) : top_age;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Totals for the result being written
  // --------------------------------------------------------------------------
  logic             is_modify;
  logic [CNT_W-1:0] hits_d;
  logic [CNT_W-1:0] misses_d;
  logic [CNT_W-1:0] evicts_d;

  assign is_modify = (cmd_q == CMD_MODIFY);
  assign hits_d    = hits_q + CNT_W'(hit_q) + CNT_W'(is_modify);
  assign misses_d  = misses_q + CNT_W'(!hit_q);
  assign evicts_d  = evicts_q + CNT_W'(!hit_q && !inv_q);

  // --------------------------------------------------------------------------
  // Sequencer and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      way_q         <= '0;
      hits_q        <= '0;
      misses_q      <= '0;
      evicts_q      <= '0;
      out_valid_q   <= 1'b0;
      out_outcome_q <= OUT_HIT;
      out_second_q  <= 1'b0;
      hit_q         <= 1'b0;
      inv_q         <= 1'b0;
    end else begin
      // output register: loaded on write-back, emptied on a result transfer
      if (write_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // sweep valid/age rows after reset
        ST_CLEAR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == SET_W'(MAX_SETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= cmd_e'(s_axis_tuser);
            addr_q  <= s_axis_tdata[TAG_W-1:0];
            state_q <= ST_SPLIT;
          end
        end

        // set index drives the row read
        ST_SPLIT: begin
          set_q   <= set_d;
          tag_q   <= tag_d;
          hit_q   <= 1'b0;
          inv_q   <= 1'b0;
          way_q   <= '0;
          state_q <= ST_SCAN;
        end

        // first match, first empty way, oldest way
        ST_SCAN: begin
          if (!hit_q && cur_match) begin
            hit_q     <= 1'b1;
            hit_way_q <= way_q;
            hit_age_q <= cur_age;
          end
          if (!inv_q && !cur_valid) begin
            inv_q     <= 1'b1;
            inv_way_q <= way_q;
          end
          if (way_q == '0 || cur_age > max_age_q) begin
            max_age_q <= cur_age;
            max_way_q <= way_q;
          end
          if (scan_last) begin
            way_q   <= '0;
            state_q <= ST_UPDATE;
          end else begin
            way_q <= way_q + WAY_W'(1);
          end
        end

        // rebuild the row one way at a time
        ST_UPDATE: begin
          upd_valid_q[way_q] <= nxt_valid;
          upd_age_q[way_q]   <= nxt_age;
          if (upd_last) begin
            state_q <= ST_WRITE;
          end else begin
            way_q <= way_q + WAY_W'(1);
          end
        end

        // write back and post the result once the output register is free
        ST_WRITE: begin
          if (write_fire) begin
            hits_q        <= hits_d;
            misses_q      <= misses_d;
            evicts_q      <= evicts_d;
            out_second_q  <= is_modify;
            out_outcome_q <= hit_q ? OUT_HIT : (inv_q ? OUT_FILL : OUT_EVICT);
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {evicts_q, misses_q, hits_q};
  assign m_axis_tuser  = {out_second_q, out_outcome_q};

endmodule

// ===== rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
